FILE: sv/smdc_pkg.sv
// ----------------------------------------------------------------------------
// smdc_pkg
// Shared types, register indexes, defaults and the sine table function for
// the stereo modulated delay chorus.
// ----------------------------------------------------------------------------
`default_nettype none

package smdc_pkg;

    localparam int DELAY_DEPTH_DEF     = 4096;
    localparam int SINE_TABLE_SIZE_DEF = 256;

    localparam int SAMPLE_W = 24;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_DELAY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SWING_DEPTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DELAY    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIX_GAIN     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_OFFSET = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_ALPHA = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FLAGS        = 3'd7;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_sample;
        logic signed [SAMPLE_W-1:0] right_sample;
    } in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_out;
        logic signed [SAMPLE_W-1:0] right_out;
    } out_t;

    typedef struct packed {
        logic ch;
        logic latch_in;
        logic mem_wr;
        logic lfo_en;
        logic dly_en;
        logic rd_lo;
        logic rd_hi;
        logic s0_en;
        logic tap_en;
        logic lpf_en;
        logic mixa_en;
        logic mixb_en;
        logic commit;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic bypass;
    } status_t;

    // Q15 sine of table entry k for a table of 2^lg entries
    function automatic logic signed [17:0] sine_entry(input int k, input int lg);
        longint u;
        longint z;
        longint z2;
        longint t;
        longint s;
        longint q;
        u = longint'(k) << (32 - lg);
        q = (u >> 30) & 3;
        z = (u & 64'h3FFF_FFFF) >> 15;
        if ((q & 1) != 0) z = 32768 - z;
        z2 = (z * z) >> 15;
        t  = 21024 - ((2320 * z2) >> 15);
        t  = 51472 - ((t * z2) >> 15);
        s  = (t * z) >> 15;
        if ((q & 2) != 0) s = -s;
        return 18'(s);
    endfunction

endpackage

`default_nettype wire

FILE: sv/stereo_modulated_delay_chorus.sv
// Sequencing: the 8-step per-channel sequence runs for both channels, sharing
//   one ring read port, then the output hand-off; a bypassed frame goes
//   straight to the hand-off. A new frame is taken only after the last one
//   is handed off. A stalled result holds the next frame in the hand-off.
// Reset: synchronous active-low aresetn clears control, LFO phase, lowpass
//   state and write position and restores register defaults; ring entries
//   not yet written read as zero, no clearing pass.
// ----------------------------------------------------------------------------
// stereo_modulated_delay_chorus
// Stereo chorus top level: sequencer plus datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_modulated_delay_chorus
    import smdc_pkg::*;
#(
    parameter int DELAY_DEPTH     = DELAY_DEPTH_DEF,
    parameter int SINE_TABLE_SIZE = SINE_TABLE_SIZE_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire in_t                  s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output out_t                      m_data
);

    cmd_t    cmd;
    status_t status;

    smdc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    smdc_dp #(
        .DELAY_DEPTH     (DELAY_DEPTH),
        .SINE_TABLE_SIZE (SINE_TABLE_SIZE)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .cmd       (cmd),
        .status    (status),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

FILE: sv/smdc_ctrl.sv
// ----------------------------------------------------------------------------
// smdc_ctrl
// Frame sequencer: steps the datapath through LFO, delay, tap reads,
// interpolation, lowpass and mix per channel (not in bypass), then hands off.
// ----------------------------------------------------------------------------
`default_nettype none

module smdc_ctrl
    import smdc_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    output logic         m_valid,
    input  wire logic    m_ready,
    input  wire status_t status,
    output cmd_t         cmd
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_LFO  = 4'd1;
    localparam logic [3:0] ST_DLY  = 4'd2;
    localparam logic [3:0] ST_RD0  = 4'd3;
    localparam logic [3:0] ST_RD1  = 4'd4;
    localparam logic [3:0] ST_TAP  = 4'd5;
    localparam logic [3:0] ST_LPF  = 4'd6;
    localparam logic [3:0] ST_MIXA = 4'd7;
    localparam logic [3:0] ST_MIXB = 4'd8;
    localparam logic [3:0] ST_OUT  = 4'd9;

    logic [3:0] state_reg, state_next;
    logic       ch_reg, ch_next;
    logic       mval_reg, mval_next;
    logic       out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = mval_reg;
    assign out_free = !mval_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        ch_next    = ch_reg;
        mval_next  = mval_reg && !m_ready;
        cmd        = '0;
        cmd.ch     = ch_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.latch_in = 1'b1;
                    ch_next      = 1'b0;
                    state_next   = status.bypass ? ST_OUT : ST_LFO;
                end
            end
            ST_LFO: begin
                cmd.lfo_en = 1'b1;
                cmd.mem_wr = !ch_reg;
                state_next = ST_DLY;
            end
            ST_DLY: begin
                cmd.dly_en = 1'b1;
                state_next = ST_RD0;
            end
            ST_RD0: begin
                cmd.rd_lo  = 1'b1;
                state_next = ST_RD1;
            end
            ST_RD1: begin
                cmd.rd_hi  = 1'b1;
                cmd.s0_en  = 1'b1;
                state_next = ST_TAP;
            end
            ST_TAP: begin
                cmd.tap_en = 1'b1;
                state_next = ST_LPF;
            end
            ST_LPF: begin
                cmd.lpf_en = 1'b1;
                state_next = ST_MIXA;
            end
            ST_MIXA: begin
                cmd.mixa_en = 1'b1;
                state_next  = ST_MIXB;
            end
            ST_MIXB: begin
                cmd.mixb_en = 1'b1;
                if (ch_reg) begin
                    cmd.commit = 1'b1;
                    state_next = ST_OUT;
                end else begin
                    ch_next    = 1'b1;
                    state_next = ST_LFO;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    mval_next    = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ch_reg    <= 1'b0;
            mval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
            mval_reg  <= mval_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/smdc_dp.sv
// ----------------------------------------------------------------------------
// smdc_dp
// Datapath: configuration registers, LFO, delay ring, interpolating tap,
// one-pole lowpass and saturating wet/dry mix.
// ----------------------------------------------------------------------------
`default_nettype none

module smdc_dp
    import smdc_pkg::*;
#(
    parameter int DELAY_DEPTH     = DELAY_DEPTH_DEF,
    parameter int SINE_TABLE_SIZE = SINE_TABLE_SIZE_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    input  wire in_t                  s_data,
    input  wire cmd_t                 cmd,
    output status_t                   status,
    output out_t                      m_data
);

    localparam int AW     = $clog2(DELAY_DEPTH);
    localparam int SINE_LG = $clog2(SINE_TABLE_SIZE);

    logic [23:0] phase_step_reg;
    logic [19:0] center_reg, swing_reg, min_reg;
    logic [15:0] mix_reg, alpha_reg;
    logic [31:0] offset_reg;
    logic [1:0]  flags_reg;

    logic [31:0]        phase_reg;
    logic [AW-1:0]      wp_reg;
    logic               full_reg;
    logic signed [31:0] sm_reg [2];

    in_t  in_reg;
    out_t res_reg;
    out_t out_reg;

    logic [47:0] mem [DELAY_DEPTH];
    logic [47:0] rd_data_reg;
    logic        rd_ok_reg;

    logic signed [17:0]  lfo_reg;
    logic [AW+7:0]       rp_reg;
    logic signed [23:0]  s0_reg;
    logic signed [23:0]  tap_reg;
    logic signed [23:0]  wet_reg;
    logic signed [41:0]  pa_reg;

    logic signed [17:0] sine_rom [SINE_TABLE_SIZE];

    for (genvar k = 0; k < SINE_TABLE_SIZE; k++) begin : g_sine
        assign sine_rom[k] = sine_entry(k, SINE_LG);
    end

    logic [16:0] mix_sat, alpha_sat;
    assign mix_sat   = (mix_reg > 16'd32768) ? 17'd32768 : {1'b0, mix_reg};
    assign alpha_sat = (alpha_reg > 16'd32768) ? 17'd32768 : {1'b0, alpha_reg};

    assign status.bypass = flags_reg[1] || (mix_reg <= 16'd3);
    assign m_data = out_reg;

    // LFO
    logic [31:0]        ph;
    logic [32:0]        tri_d;
    logic signed [18:0] tri_v;
    logic signed [17:0] lfo_v;
    always_comb begin
        ph    = cmd.ch ? phase_reg + offset_reg : phase_reg;
        tri_d = ph[31] ? (33'h1_0000_0000 - {1'b0, ph}) : {1'b0, ph};
        tri_v = $signed({1'b0, tri_d[32:15]}) - 19'sd32768;
        lfo_v = flags_reg[0] ? tri_v[17:0] : sine_rom[ph[31 -: SINE_LG]];
    end

    // delay and read position
    logic signed [38:0] dprod;
    logic signed [38:0] dsh;
    logic signed [23:0] dsum;
    logic [23:0]        dfin;
    logic [AW+7:0]      rp_v;
    always_comb begin
        dprod = $signed({1'b0, swing_reg}) * lfo_reg;
        dsh   = dprod >>> 15;
        dsum  = $signed({4'b0, center_reg}) + dsh[23:0];
        dfin  = (dsum < $signed({4'b0, min_reg})) ? {4'b0, min_reg} : dsum;
        rp_v  = {wp_reg, 8'b0} - dfin[AW+7:0];
    end

    logic [AW-1:0] i0, i1, raddr;
    assign i0    = rp_reg[AW+7:8];
    assign i1    = i0 + 1'b1;
    assign raddr = cmd.rd_hi ? i1 : i0;

    logic signed [23:0] rd_smp;
    assign rd_smp = !rd_ok_reg ? 24'sd0 :
                    (cmd.ch ? rd_data_reg[47:24] : rd_data_reg[23:0]);

    // interpolation
    logic signed [24:0] idiff;
    logic signed [33:0] iprod;
    logic signed [33:0] ish;
    logic signed [23:0] tap_v;
    always_comb begin
        idiff = {rd_smp[23], rd_smp} - {s0_reg[23], s0_reg};
        iprod = $signed({1'b0, rp_reg[7:0]}) * idiff;
        ish   = iprod >>> 8;
        tap_v = s0_reg + ish[23:0];
    end

    // lowpass
    logic signed [31:0] sm_cur;
    logic signed [33:0] ldiff;
    logic signed [51:0] lprod;
    logic signed [51:0] lsh;
    logic signed [31:0] sm_new;
    always_comb begin
        sm_cur = sm_reg[cmd.ch];
        ldiff  = {{2{tap_reg[23]}}, tap_reg, 8'b0} - {{2{sm_cur[31]}}, sm_cur};
        lprod  = $signed({1'b0, alpha_sat}) * ldiff;
        lsh    = lprod >>> 15;
        sm_new = sm_cur + lsh[31:0];
    end

    // mix
    logic signed [23:0] dry;
    logic [16:0]        dry_g;
    logic signed [41:0] pa_v, pb_v;
    logic signed [42:0] msum, msh;
    logic signed [23:0] mo;
    always_comb begin
        dry   = cmd.ch ? in_reg.right_sample : in_reg.left_sample;
        dry_g = 17'd32768 - mix_sat;
        pa_v  = dry * $signed({1'b0, dry_g});
        pb_v  = wet_reg * $signed({1'b0, mix_sat});
        msum  = {pa_reg[41], pa_reg} + {pb_v[41], pb_v} + 43'sd16384;
        msh   = msum >>> 15;
        if (msh > 43'sd8388607)       mo = 24'sh7FFFFF;
        else if (msh < -43'sd8388608) mo = 24'sh800000;
        else                          mo = msh[23:0];
    end

    always_ff @(posedge aclk) begin
        if (cmd.mem_wr) begin
            mem[wp_reg] <= {in_reg.right_sample, in_reg.left_sample};
        end
        if (cmd.rd_lo || cmd.rd_hi) begin
            rd_data_reg <= mem[raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            in_reg  <= s_data;
            res_reg <= {s_data.left_sample, s_data.right_sample};
        end
        if (cmd.lfo_en)  lfo_reg <= lfo_v;
        if (cmd.dly_en)  rp_reg  <= rp_v;
        if (cmd.s0_en)   s0_reg  <= rd_smp;
        if (cmd.tap_en)  tap_reg <= tap_v;
        if (cmd.lpf_en)  wet_reg <= sm_new[31:8];
        if (cmd.mixa_en) pa_reg  <= pa_v;
        if (cmd.mixb_en) begin
            if (cmd.ch) res_reg.right_out <= mo;
            else        res_reg.left_out  <= mo;
        end
        if (cmd.out_load) out_reg <= res_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_step_reg <= 24'd44739;
            center_reg     <= 20'd147456;
            swing_reg      <= 20'd0;
            min_reg        <= 20'd256;
            mix_reg        <= 16'd16384;
            offset_reg     <= 32'd0;
            alpha_reg      <= 16'd13357;
            flags_reg      <= 2'd0;
            phase_reg      <= '0;
            wp_reg         <= '0;
            full_reg       <= 1'b0;
            sm_reg[0]      <= '0;
            sm_reg[1]      <= '0;
            rd_ok_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_PHASE_STEP:   phase_step_reg <= cfg_wdata[23:0];
                    REG_CENTER_DELAY: center_reg     <= cfg_wdata[19:0];
                    REG_SWING_DEPTH:  swing_reg      <= cfg_wdata[19:0];
                    REG_MIN_DELAY:    min_reg        <= cfg_wdata[19:0];
                    REG_MIX_GAIN:     mix_reg        <= cfg_wdata[15:0];
                    REG_WIDTH_OFFSET: offset_reg     <= cfg_wdata;
                    REG_SMOOTH_ALPHA: alpha_reg      <= cfg_wdata[15:0];
                    REG_FLAGS:        flags_reg      <= cfg_wdata[1:0];
                    default: ;
                endcase
            end
            if (cmd.rd_lo || cmd.rd_hi) begin
                rd_ok_reg <= full_reg || (raddr <= wp_reg);
            end
            if (cmd.lpf_en) sm_reg[cmd.ch] <= sm_new;
            if (cmd.commit) begin
                phase_reg <= phase_reg + {8'b0, phase_step_reg};
                wp_reg    <= wp_reg + 1'b1;
                if (&wp_reg) full_reg <= 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/smdc_checker.sv
// ----------------------------------------------------------------------------
// smdc_checker
// Port-level checks for the stereo chorus, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module smdc_checker
    import smdc_pkg::*;
(
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_valid,
    input wire logic s_ready,
    input wire logic m_valid,
    input wire logic m_ready,
    input wire out_t m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken while frame in flight");

    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("bad state after reset");

endmodule

bind stereo_modulated_delay_chorus smdc_checker u_smdc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
